@@ design/lpb_pkg.sv @@
`default_nettype none
package lpb_pkg;

    // Blend mode codes; undefined codes behave as normal
    typedef enum logic [3:0] {
        MODE_NORMAL     = 4'd0,
        MODE_MULTIPLY   = 4'd1,
        MODE_DIVIDE     = 4'd2,
        MODE_DIFFERENCE = 4'd3,
        MODE_EXCLUSION  = 4'd4,
        MODE_LIGHTEN    = 4'd5,
        MODE_DARKEN     = 4'd6,
        MODE_OR         = 4'd7,
        MODE_AVERAGE    = 4'd8,
        MODE_ADD        = 4'd9,
        MODE_SUBTRACT   = 4'd10
    } t_mode;

    // Configuration register indexes
    localparam logic CFG_MODE    = 1'b0;
    localparam logic CFG_OPACITY = 1'b1;

    localparam int CH_W      = 8;
    localparam int WEIGHT_W  = 2 * CH_W;
    localparam int NUM_LANES = 3;
    localparam int PIPE_LEN  = 6;

    // Reciprocal scaling for the divide mode and the weight normalization
    localparam int          RECIP_SHIFT = 24;
    localparam int          RECIP_W     = RECIP_SHIFT + 1;
    localparam int          NORM_DIV    = 65025;
    localparam logic [16:0] NORM_RECIP  = 17'd66051;   // floor(2^32 / 65025)
    localparam int          NORM_SHIFT  = 32;

    localparam logic [3:0] MODE_RESET    = 4'd0;
    localparam logic [7:0] OPACITY_RESET = 8'd255;

endpackage
`default_nettype wire

@@ design/lpb_lane.sv @@
`default_nettype none
module lpb_lane (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire lpb_pkg::t_mode                    i_mode,
    input  wire logic [lpb_pkg::WEIGHT_W-1:0]      i_weight,
    input  wire logic [lpb_pkg::CH_W-1:0]          i_layer,
    input  wire logic [lpb_pkg::CH_W-1:0]          i_base,
    output logic      [lpb_pkg::CH_W-1:0]          o_res
);

    localparam int P_W = 2 * lpb_pkg::CH_W + lpb_pkg::RECIP_W;

    // Reciprocal table ceil(2^24 / l), zero divisor taken as one
    logic [lpb_pkg::RECIP_W-1:0] recip_tbl [256];
    for (genvar g = 0; g < 256; g++) begin : g_recip
        localparam int RV = (g == 0) ? (1 << lpb_pkg::RECIP_SHIFT)
                          : (((1 << lpb_pkg::RECIP_SHIFT) + g - 1) / g);
        assign recip_tbl[g] = RV[lpb_pkg::RECIP_W-1:0];
    end

    // Stage 2: quotient product for divide
    logic [P_W-1:0]                  r_p;
    logic [lpb_pkg::CH_W-1:0]        r_l2, r_d2;
    logic [lpb_pkg::WEIGHT_W-1:0]    r_w2;
    lpb_pkg::t_mode                  r_m2;
    logic [15:0]                     num;
    assign num = {i_base, 8'd0} - {8'd0, i_base};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p  <= P_W'(num) * P_W'(recip_tbl[i_layer]);
            r_l2 <= i_layer;
            r_d2 <= i_base;
            r_w2 <= i_weight;
            r_m2 <= i_mode;
        end
    end

    // Stage 3: blend value and signed distance to base
    logic [15:0] prod_ld, quo, mul_t;
    logic [8:0]  sum_ld;
    logic [7:0]  mul_v, div_v, bv;
    logic [7:0]  r_diff, r_d3;
    logic        r_neg3;
    logic [lpb_pkg::WEIGHT_W-1:0] r_w3;

    assign prod_ld = {8'd0, r_l2} * {8'd0, r_d2};
    // Divide by 255 as (x + 1 + (x >> 8)) >> 8, exact for x up to 255*255
    assign mul_t   = prod_ld + 16'd1 + {8'd0, prod_ld[15:8]};
    assign mul_v   = mul_t[15:8];
    assign quo     = r_p[lpb_pkg::RECIP_SHIFT +: 16];
    assign div_v   = (quo > 16'd255) ? 8'd255 : quo[7:0];
    assign sum_ld  = {1'b0, r_l2} + {1'b0, r_d2};

    always_comb begin
        unique case (r_m2)
            lpb_pkg::MODE_MULTIPLY:   bv = mul_v;
            lpb_pkg::MODE_DIVIDE:     bv = div_v;
            lpb_pkg::MODE_DIFFERENCE: bv = (r_l2 > r_d2) ? r_l2 - r_d2 : r_d2 - r_l2;
            lpb_pkg::MODE_EXCLUSION:  bv = r_l2 ^ r_d2;
            lpb_pkg::MODE_LIGHTEN:    bv = (r_l2 > r_d2) ? r_l2 : r_d2;
            lpb_pkg::MODE_DARKEN:     bv = (r_l2 < r_d2) ? r_l2 : r_d2;
            lpb_pkg::MODE_OR:         bv = r_l2 | r_d2;
            lpb_pkg::MODE_AVERAGE:    bv = sum_ld[8:1];
            lpb_pkg::MODE_ADD:        bv = sum_ld[8] ? 8'd255 : sum_ld[7:0];
            lpb_pkg::MODE_SUBTRACT:   bv = (r_d2 > r_l2) ? r_d2 - r_l2 : 8'd0;
            default:                  bv = r_l2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg3 <= bv < r_d2;
            r_diff <= (bv < r_d2) ? r_d2 - bv : bv - r_d2;
            r_d3   <= r_d2;
            r_w3   <= r_w2;
        end
    end

    // Stage 4: scale distance by weight
    logic [23:0] r_x4;
    logic [7:0]  r_d4;
    logic        r_neg4;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x4   <= {16'd0, r_diff} * {8'd0, r_w3};
            r_d4   <= r_d3;
            r_neg4 <= r_neg3;
        end
    end

    // Stage 5: estimate quotient by 65025 via reciprocal (may be one low)
    logic [40:0] est_p;
    logic [23:0] r_x5;
    logic [7:0]  r_q5, r_d5;
    logic        r_neg5;
    assign est_p = {17'd0, r_x4} * {24'd0, lpb_pkg::NORM_RECIP};
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q5   <= est_p[lpb_pkg::NORM_SHIFT +: 8];
            r_x5   <= r_x4;
            r_d5   <= r_d4;
            r_neg5 <= r_neg4;
        end
    end

    // Stage 6: correct the estimate and move base toward blend value
    logic [23:0] qm, rem;
    logic [7:0]  mag;
    assign qm  = {r_q5, 16'd0} - {7'd0, r_q5, 9'd0} + {16'd0, r_q5};
    assign rem = r_x5 - qm;
    assign mag = (rem >= 24'(lpb_pkg::NORM_DIV)) ? r_q5 + 8'd1 : r_q5;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res <= r_neg5 ? r_d5 - mag : r_d5 + mag;
        end
    end

endmodule
`default_nettype wire

@@ design/layer_pixel_blend.sv @@
// Layer pixel blend: composites a layer pixel over a display pixel with a
// selectable blend mode, weighted by layer opacity times layer alpha.
// Fully pipelined, one item per clock while the output is not stalled; six
// register stages, the first holding the item and the shared weight and the
// rest inside each of the three channel lanes. The
// whole pipe stalls only while the output holds a result that is not taken.
// Write blend_mode (index 0) and layer_opacity (index 1) while idle.
`default_nettype none
module layer_pixel_blend (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_addr,
    input  wire logic [7:0]  i_cfg_wdata,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // layer_blue, layer_green, layer_red, layer_alpha, base_blue, base_green, base_red
    input  wire logic [55:0] i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // out_blue, out_green, out_red
    output logic [23:0]      o_m_axis_tdata
);

    localparam int CW = lpb_pkg::CH_W;

    logic [3:0] r_mode;
    logic [7:0] r_opacity;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= lpb_pkg::MODE_RESET;
            r_opacity <= lpb_pkg::OPACITY_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == lpb_pkg::CFG_MODE) r_mode <= i_cfg_wdata[3:0];
            if (i_cfg_addr == lpb_pkg::CFG_OPACITY) r_opacity <= i_cfg_wdata;
        end
    end

    // Pipe advance and valid tracking
    logic                          en;
    logic [lpb_pkg::PIPE_LEN-1:0]  r_vld;
    assign en              = !r_vld[lpb_pkg::PIPE_LEN-1] || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_vld[lpb_pkg::PIPE_LEN-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[lpb_pkg::PIPE_LEN-2:0], i_s_axis_tvalid};
        end
    end

    // Stage 1: register item and shared weight
    logic [lpb_pkg::WEIGHT_W-1:0] r_weight;
    lpb_pkg::t_mode               r_m1;
    logic [CW-1:0]                r_layer [lpb_pkg::NUM_LANES];
    logic [CW-1:0]                r_base  [lpb_pkg::NUM_LANES];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_weight <= {8'd0, r_opacity} * {8'd0, i_s_axis_tdata[3*CW +: CW]};
            r_m1     <= lpb_pkg::t_mode'(r_mode);
            for (int c = 0; c < lpb_pkg::NUM_LANES; c++) begin
                r_layer[c] <= i_s_axis_tdata[c*CW +: CW];
                r_base[c]  <= i_s_axis_tdata[(4+c)*CW +: CW];
            end
        end
    end

    // Channel lanes; merge results into the output word
    for (genvar c = 0; c < lpb_pkg::NUM_LANES; c++) begin : g_lane
        lpb_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_mode   (r_m1),
            .i_weight (r_weight),
            .i_layer  (r_layer[c]),
            .i_base   (r_base[c]),
            .o_res    (o_m_axis_tdata[c*CW +: CW])
        );
    end

`ifndef SYNTHESIS
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> r_vld == '0) else $error("valid pipe not cleared");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[lpb_pkg::PIPE_LEN-1] && !i_m_axis_tready) |=> $stable(r_vld))
        else $error("pipe moved during stall");
    a_no_accept_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input taken while output stalled");
`endif

endmodule
`default_nettype wire

@@ test/lpb_checker.sv @@
`default_nettype none
module lpb_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_addr,
    input  wire logic [7:0]  i_cfg_wdata,
    input  wire logic        i_s_axis_tvalid,
    input  wire logic        i_s_axis_tready,
    // layer_blue, layer_green, layer_red, layer_alpha, base_blue, base_green, base_red
    input  wire logic [55:0] i_s_axis_tdata,
    input  wire logic        i_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // out_blue, out_green, out_red
    input  wire logic [23:0] i_m_axis_tdata,
    output int               o_errors,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [3:0]  mode_q;
    logic [7:0]  opacity_q;
    logic [23:0] blended_q[$];

    assign o_pending = blended_q.size();

    // Blend value of one channel for the current mode
    function automatic logic [7:0] mode_value(logic [3:0] mode, logic [7:0] l, logic [7:0] d);
        int unsigned v;
        case (mode)
            lpb_pkg::MODE_MULTIPLY:   return (l * d) / 255;
            lpb_pkg::MODE_DIVIDE: begin
                v = (d * 255) / ((l == 0) ? 1 : l);
                return (v > 255) ? 8'd255 : v[7:0];
            end
            lpb_pkg::MODE_DIFFERENCE: return (l > d) ? l - d : d - l;
            lpb_pkg::MODE_EXCLUSION:  return l ^ d;
            lpb_pkg::MODE_LIGHTEN:    return (l > d) ? l : d;
            lpb_pkg::MODE_DARKEN:     return (l < d) ? l : d;
            lpb_pkg::MODE_OR:         return l | d;
            lpb_pkg::MODE_AVERAGE:    return ({1'b0, l} + d) >> 1;
            lpb_pkg::MODE_ADD: begin
                v = l + d;
                return (v > 255) ? 8'd255 : v[7:0];
            end
            lpb_pkg::MODE_SUBTRACT:   return (d > l) ? d - l : 8'd0;
            default:                  return l;
        endcase
    endfunction

    // Composite one pixel pair under the current settings
    function automatic logic [23:0] composite(logic [55:0] px);
        logic [23:0] res;
        logic [7:0]  l, d, b, alpha;
        int unsigned weight, mag;
        alpha = px[31:24];
        weight = opacity_q * alpha;
        for (int c = 0; c < 3; c++) begin
            l = px[8*c +: 8];
            d = px[32 + 8*c +: 8];
            if (alpha == 0) begin
                res[8*c +: 8] = d;
            end else begin
                b = mode_value(mode_q, l, d);
                if (b >= d) begin
                    mag = ((b - d) * weight) / 65025;
                    res[8*c +: 8] = d + mag;
                end else begin
                    mag = ((d - b) * weight) / 65025;
                    res[8*c +: 8] = d - mag;
                end
            end
        end
        return res;
    endfunction

    // Track settings, queue predictions, compare results
    always @(posedge i_clk) begin
        logic [23:0] want;
        int          bad;
        bad = 0;
        if (!i_rst_n) begin
            mode_q    <= lpb_pkg::MODE_RESET;
            opacity_q <= lpb_pkg::OPACITY_RESET;
            blended_q.delete();
            o_errors  <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == lpb_pkg::CFG_MODE) mode_q <= i_cfg_wdata[3:0];
                else opacity_q <= i_cfg_wdata;
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                blended_q.push_back(composite(i_s_axis_tdata));
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (blended_q.size() == 0) begin
                    $display("%t: unexpected item %h", $realtime, i_m_axis_tdata);
                    bad = bad + 1;
                end else begin
                    want = blended_q.pop_front();
                    for (int c = 0; c < 3; c++)
                        if (want[8*c +: 8] !== i_m_axis_tdata[8*c +: 8]) begin
                            $display("%t: channel %0d expected %h got %h", $realtime, c,
                                     want[8*c +: 8], i_m_axis_tdata[8*c +: 8]);
                            bad = bad + 1;
                        end
                end
            end
            if (bad != 0) o_errors <= o_errors + bad;
        end
    end
endmodule
`default_nettype wire

@@ test/tb_layer_pixel_blend.sv @@
`default_nettype none
module tb_layer_pixel_blend;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic        i_cfg_addr = 0;
    logic [7:0]  i_cfg_wdata = 0;
    logic        i_s_axis_tvalid = 0;
    logic        o_s_axis_tready;
    logic [55:0] i_s_axis_tdata = 0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 0;
    logic [23:0] o_m_axis_tdata;
    int          errors, pending;
    bit          hold_off = 0;

    always #2 i_clk = ~i_clk;

    layer_pixel_blend uut (.*);

    lpb_checker chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_addr, .i_cfg_wdata,
        .i_s_axis_tvalid, .i_s_axis_tready(o_s_axis_tready), .i_s_axis_tdata,
        .i_m_axis_tvalid(o_m_axis_tvalid), .i_m_axis_tready,
        .i_m_axis_tdata(o_m_axis_tdata), .o_errors(errors), .o_pending(pending)
    );

    function automatic int gap_len();
        if ($urandom_range(0, 2) == 0) return 0;
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    // Receiver: random stalls, a long hold-off on request
    initial begin
        int n;
        @(negedge i_clk);
        forever begin
            if (hold_off) begin
                i_m_axis_tready <= 0;
                repeat (60) @(negedge i_clk);
                hold_off = 0;
            end
            i_m_axis_tready <= 1;
            n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            repeat (n) @(negedge i_clk);
            n = gap_len();
            if (n > 0) i_m_axis_tready <= 0;
            repeat (n) @(negedge i_clk);
        end
    end

    // Offer one pixel pair and wait for it to be taken
    task automatic send_pixel(logic [55:0] px);
        int n;
        n = ($urandom_range(0, 1) == 0) ? 0 : gap_len();
        if (n > 0) begin
            i_s_axis_tvalid <= 0;
            repeat (n) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1;
        i_s_axis_tdata  <= px;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (lpb_pkg::PIPE_LEN + 4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        i_cfg_we    <= 1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 0;
    endtask

    function automatic logic [55:0] rand_pixel();
        logic [55:0] px;
        px = {$urandom, $urandom};
        // bias alpha toward its extremes now and then
        case ($urandom_range(0, 7))
            0: px[31:24] = 8'd0;
            1: px[31:24] = 8'd255;
            default: ;
        endcase
        return px;
    endfunction

    initial begin
        logic [7:0] opac[4];
        opac = '{8'd255, 8'd0, 8'd1, 8'd128};
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: extremes and zero alpha under reset settings; divide by zero channel follows
        send_pixel({8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0});
        send_pixel({8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255});
        send_pixel({8'd10, 8'd20, 8'd30, 8'd0, 8'd1, 8'd2, 8'd3});
        drain();
        for (int m = 0; m < 16; m++) begin
            write_reg(lpb_pkg::CFG_MODE, 8'(m));
            send_pixel({8'd200, 8'd0, 8'd255, 8'd255, 8'd0, 8'd100, 8'd255});
            drain();
        end
        write_reg(lpb_pkg::CFG_MODE, 8'(lpb_pkg::MODE_DIVIDE));
        write_reg(lpb_pkg::CFG_OPACITY, 8'd0);
        send_pixel({8'd90, 8'd90, 8'd90, 8'd255, 8'd0, 8'd7, 8'd9});
        drain();

        // Random phases over modes and opacities, extremes included
        for (int ph = 0; ph < 24; ph++) begin
            write_reg(lpb_pkg::CFG_MODE, 8'((ph < 16) ? ph : $urandom_range(0, 15)));
            write_reg(lpb_pkg::CFG_OPACITY, (ph < 4) ? opac[ph] : 8'($urandom));
            if (ph == 5) hold_off = 1;
            for (int k = 0; k < 47; k++) send_pixel(rand_pixel());
            drain();
        end

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire
